// ===== rtl/tt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent package
// Shared types, command and status bundles, and fixed-point constants.
// ----------------------------------------------------------------------------
package tt_pkg;

    // Fraction bits of the output tangent and of the internal unit vectors
    localparam int TAN_FRAC  = 14;
    localparam int UNIT_FRAC = 30;
    // Magnitudes are reduced until they fit below 2^RED_BITS
    localparam int RED_BITS  = 30;

    // Determinant threshold 1e-6 in Q2.60
    localparam logic signed [63:0] DET_EPS = 64'sd1152921504607;

    // Output clamp limits: +-1.0 in Q1.TAN_FRAC, then the 16-bit range
    localparam logic signed [31:0] TAN_ONE = 32'sd1 <<< TAN_FRAC;
    localparam logic signed [31:0] TAN_HI  = (TAN_ONE > 32'sd32767) ? 32'sd32767 : TAN_ONE;
    localparam logic signed [31:0] TAN_LO  = (TAN_ONE > 32'sd32768) ? -32'sd32768 : -TAN_ONE;

    // Iteration counts of the bit-serial units
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 32;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] tu;
        logic signed [31:0] tv;
    } t_vtx;

    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic [1:0]         corner;
        logic               degen;
        logic               last;
    } t_res;

    // Vector being normalized
    typedef enum logic [2:0] {
        VS_E1,
        VS_E2,
        VS_U1,
        VS_U2,
        VS_TV
    } t_vsel;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MS_SQ,
        MS_DET0,
        MS_DET1,
        MS_TV0,
        MS_TV1
    } t_msel;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_HOLD,
        OP_CAPTURE,
        OP_VLOAD,
        OP_VMAX,
        OP_VRED,
        OP_MUL,
        OP_SUM_ADD,
        OP_SQRT_GO,
        OP_DIV_GO,
        OP_DIV_STORE,
        OP_VSTORE,
        OP_ACC_LOAD,
        OP_ACC_SUB,
        OP_DET_LATCH,
        OP_TV_STORE,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op        op;
        t_vsel      vsel;
        t_msel      msel;
        logic [1:0] idx;
        logic [1:0] corner;
    } t_cmd;

    typedef struct packed {
        logic red_done;
        logic sqrt_done;
        logic div_done;
        logic degen;
        logic out_full;
    } t_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_VLOAD,
        S_VMAX,
        S_VRED,
        S_SQ_MUL,
        S_SQ_ADD,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_VSTORE,
        S_DET_MUL0,
        S_DET_ACC0,
        S_DET_MUL1,
        S_DET_ACC1,
        S_DET_CHK,
        S_TV_MUL0,
        S_TV_ACC0,
        S_TV_MUL1,
        S_TV_ACC1,
        S_OUT
    } t_state;

endpackage

// ===== rtl/tt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent channels
// Valid/ready channels for vertex words in and tangent words out.
// ----------------------------------------------------------------------------
interface tt_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tt_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic [1:0]         corner_index;
    logic               degenerate;
    logic               last_of_triangle;

    modport source (output valid, tangent_x, tangent_y, tangent_z, corner_index,
                    degenerate, last_of_triangle, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, corner_index,
                    degenerate, last_of_triangle, output ready);
endinterface

// ===== rtl/tt_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent square root
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tt_isqrt import tt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_rad,
    output logic [30:0] o_root,
    output logic        o_done
);

    localparam int CW = $clog2(SQRT_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [61:0]   r_x;
    logic [34:0]   r_rem;
    logic [30:0]   r_root;

    logic [34:0]   w_rem2;
    logic [34:0]   w_trial;
    logic          w_ge;

    // Bring down two radicand bits and test the trial divisor
    always_comb begin
        w_rem2  = {r_rem[32:0], r_x[61:60]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SQRT_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[59:0], 2'b00};
            r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[29:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ===== rtl/tt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent divider
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// ----------------------------------------------------------------------------
module tt_div import tt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_num,
    input  logic [30:0] i_den,
    output logic [31:0] o_quo,
    output logic        o_done
);

    localparam int CW = $clog2(DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_num;
    logic [31:0]   r_rem;
    logic [30:0]   r_den;
    logic [31:0]   r_quo;

    logic [31:0]   w_rem2;
    logic          w_ge;

    // Shift in the next numerator bit and compare
    always_comb begin
        w_rem2 = {r_rem[30:0], r_num[31]};
        w_ge   = (w_rem2 >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num[61:32]};
            r_num <= i_num[31:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
            r_num <= {r_num[30:0], 1'b0};
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== rtl/tt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent datapath
// Corner storage, vector normalizer with shared multiplier, square root and
// divider, determinant and tangent arithmetic, and the output register.
// ----------------------------------------------------------------------------
module tt_dp import tt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_vtx  i_vtx,
    output t_stat o_stat,
    output t_res  o_res,
    output logic  o_res_valid,
    input  logic  i_res_ready
);

    t_vtx               r_c0, r_c1, r_c2;
    t_vtx               w_a, w_b, w_c;

    logic signed [62:0] w_d   [3];
    logic [62:0]        w_abs [3];
    logic [62:0]        w_max;

    logic [62:0]        r_m   [3];
    logic               r_neg [3];
    logic [62:0]        r_mx;
    logic [61:0]        r_sum;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_n   [3];
    logic signed [31:0] r_e1  [3];
    logic signed [31:0] r_e2  [3];
    logic signed [31:0] r_u1  [2];
    logic signed [31:0] r_u2  [2];
    logic signed [62:0] r_tv  [3];
    logic               r_degen;
    logic               r_det_neg;
    t_res               r_res;
    logic               r_res_valid;

    logic signed [31:0] w_ma, w_mb;
    logic [61:0]        w_kx;
    logic [61:0]        w_num;
    logic [30:0]        w_len;
    logic [31:0]        w_quo;
    logic               w_sqrt_done;
    logic               w_div_done;
    logic               w_degen;
    logic signed [63:0] w_tdiff;
    logic signed [31:0] w_q;

    function automatic logic [15:0] f_sat(input logic signed [31:0] v);
        logic signed [31:0] c;
        c = v;
        if (c > TAN_HI) c = TAN_HI;
        if (c < TAN_LO) c = TAN_LO;
        return c[15:0];
    endfunction

    // Order the corners so that A is the current one, then B and C cyclically
    always_comb begin
        case (i_cmd.corner)
            2'd1: begin
                w_a = r_c1; w_b = r_c2; w_c = r_c0;
            end
            2'd2: begin
                w_a = r_c2; w_b = r_c0; w_c = r_c1;
            end
            default: begin
                w_a = r_c0; w_b = r_c1; w_c = r_c2;
            end
        endcase
    end

    // Select the vector to normalize
    always_comb begin
        for (int i = 0; i < 3; i++) w_d[i] = '0;
        case (i_cmd.vsel)
            VS_E1: begin
                w_d[0] = 63'(w_b.px) - 63'(w_a.px);
                w_d[1] = 63'(w_b.py) - 63'(w_a.py);
                w_d[2] = 63'(w_b.pz) - 63'(w_a.pz);
            end
            VS_E2: begin
                w_d[0] = 63'(w_c.px) - 63'(w_a.px);
                w_d[1] = 63'(w_c.py) - 63'(w_a.py);
                w_d[2] = 63'(w_c.pz) - 63'(w_a.pz);
            end
            VS_U1: begin
                w_d[0] = 63'(w_b.tu) - 63'(w_a.tu);
                w_d[1] = 63'(w_b.tv) - 63'(w_a.tv);
            end
            VS_U2: begin
                w_d[0] = 63'(w_c.tu) - 63'(w_a.tu);
                w_d[1] = 63'(w_c.tv) - 63'(w_a.tv);
            end
            VS_TV: begin
                for (int i = 0; i < 3; i++) w_d[i] = r_tv[i];
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) w_abs[i] = w_d[i][62] ? 63'(-w_d[i]) : 63'(w_d[i]);
    end

    // Largest magnitude of the loaded vector
    always_comb begin
        w_max = r_m[0];
        if (r_m[1] > w_max) w_max = r_m[1];
        if (r_m[2] > w_max) w_max = r_m[2];
    end

    // Multiplier operands
    always_comb begin
        case (i_cmd.msel)
            MS_SQ: begin
                w_ma = {2'b00, r_m[i_cmd.idx][RED_BITS-1:0]};
                w_mb = {2'b00, r_m[i_cmd.idx][RED_BITS-1:0]};
            end
            MS_DET0: begin
                w_ma = r_u1[0]; w_mb = r_u2[1];
            end
            MS_DET1: begin
                w_ma = r_u1[1]; w_mb = r_u2[0];
            end
            MS_TV0: begin
                w_ma = r_e1[i_cmd.idx]; w_mb = r_u2[1];
            end
            MS_TV1: begin
                w_ma = r_e2[i_cmd.idx]; w_mb = r_u1[1];
            end
            default: begin
                w_ma = '0; w_mb = '0;
            end
        endcase
    end

    // Divider numerator: scaled magnitude plus half the length for rounding
    always_comb begin
        w_kx  = {32'd0, r_m[i_cmd.idx][RED_BITS-1:0]};
        w_num = ((i_cmd.vsel == VS_TV) ? (w_kx << TAN_FRAC) : (w_kx << UNIT_FRAC))
              + {31'd0, w_len[30:1]};
        w_q   = (w_len == '0) ? 32'sd0 :
                (r_neg[i_cmd.idx] ? -$signed(w_quo) : $signed(w_quo));
        w_degen = (r_acc < DET_EPS) && (r_acc > -DET_EPS);
        w_tdiff = r_acc - r_prod;
    end

    tt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT_GO),
        .i_rad   (r_sum),
        .o_root  (w_len),
        .o_done  (w_sqrt_done)
    );

    tt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_GO),
        .i_num   (w_num),
        .i_den   (w_len),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // Execute the command of this cycle
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_HOLD: begin
                if (i_cmd.idx == 2'd0) r_c0 <= i_vtx;
                else                   r_c1 <= i_vtx;
            end
            OP_CAPTURE: r_c2 <= i_vtx;
            OP_VLOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= w_abs[i];
                    r_neg[i] <= w_d[i][62];
                end
            end
            OP_VMAX: begin
                r_mx  <= w_max;
                r_sum <= '0;
            end
            OP_VRED: begin
                if (r_mx[62:RED_BITS] != '0) begin
                    r_mx <= r_mx >> 1;
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end
            end
            OP_MUL:       r_prod <= w_ma * w_mb;
            OP_SUM_ADD:   r_sum <= r_sum + r_prod[61:0];
            OP_DIV_STORE: r_n[i_cmd.idx] <= w_q;
            OP_VSTORE: begin
                case (i_cmd.vsel)
                    VS_E1: for (int i = 0; i < 3; i++) r_e1[i] <= r_n[i];
                    VS_E2: for (int i = 0; i < 3; i++) r_e2[i] <= r_n[i];
                    VS_U1: for (int i = 0; i < 2; i++) r_u1[i] <= r_n[i];
                    VS_U2: for (int i = 0; i < 2; i++) r_u2[i] <= r_n[i];
                    default: ;
                endcase
            end
            OP_ACC_LOAD: r_acc <= r_prod;
            OP_ACC_SUB:  r_acc <= r_acc - r_prod;
            OP_DET_LATCH: begin
                r_degen   <= w_degen;
                r_det_neg <= r_acc[63];
            end
            OP_TV_STORE: r_tv[i_cmd.idx] <= r_det_neg ? 63'(-w_tdiff) : 63'(w_tdiff);
            OP_OUT_LOAD: begin
                r_res.corner <= i_cmd.corner;
                r_res.last   <= (i_cmd.corner == 2'd2);
                r_res.degen  <= r_degen;
                if (r_degen) begin
                    r_res.tx <= TAN_HI[15:0];
                    r_res.ty <= '0;
                    r_res.tz <= '0;
                end else begin
                    r_res.tx <= f_sat(r_n[0]);
                    r_res.ty <= f_sat(r_n[1]);
                    r_res.tz <= f_sat(r_n[2]);
                end
            end
            default: ;
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT_LOAD) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_stat.red_done  = (r_mx[62:RED_BITS] == '0);
    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.degen     = w_degen;
    assign o_stat.out_full  = r_res_valid;
    assign o_res            = r_res;
    assign o_res_valid      = r_res_valid;

endmodule

// ===== rtl/tt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent controller
// Counts corners, then steps the datapath through the four normalizations,
// the determinant, and unless it is degenerate the tangent and its normalization, for each corner.
// ----------------------------------------------------------------------------
module tt_ctrl import tt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    t_vsel      r_vsel, n_vsel;
    logic [1:0] r_idx, n_idx;
    logic [1:0] r_corner, n_corner;
    logic [1:0] r_count, n_count;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vsel   <= VS_E1;
            r_idx    <= '0;
            r_corner <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_vsel   <= n_vsel;
            r_idx    <= n_idx;
            r_corner <= n_corner;
            r_count  <= n_count;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_vsel       = r_vsel;
        n_idx        = r_idx;
        n_corner     = r_corner;
        n_count      = r_count;
        o_in_ready   = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.vsel   = r_vsel;
        o_cmd.msel   = MS_SQ;
        o_cmd.idx    = r_idx;
        o_cmd.corner = r_corner;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!r_count[1]) begin
                        o_cmd.op  = OP_HOLD;
                        o_cmd.idx = r_count;
                        n_count   = r_count + 2'd1;
                    end else begin
                        o_cmd.op = OP_CAPTURE;
                        n_count  = '0;
                        n_corner = '0;
                        n_vsel   = VS_E1;
                        n_idx    = '0;
                        n_state  = S_VLOAD;
                    end
                end
            end
            S_VLOAD: begin
                o_cmd.op = OP_VLOAD;
                n_state  = S_VMAX;
            end
            S_VMAX: begin
                o_cmd.op = OP_VMAX;
                n_state  = S_VRED;
            end
            S_VRED: begin
                o_cmd.op = OP_VRED;
                if (i_stat.red_done) begin
                    n_idx   = '0;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_MUL: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_SQ;
                n_state    = S_SQ_ADD;
            end
            S_SQ_ADD: begin
                o_cmd.op = OP_SUM_ADD;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = S_SQRT_GO;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT_GO: begin
                o_cmd.op = OP_SQRT_GO;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (i_stat.sqrt_done) n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DIV_STORE;
                    if (r_idx == 2'd2) begin
                        n_idx   = '0;
                        n_state = S_VSTORE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_VSTORE: begin
                o_cmd.op = OP_VSTORE;
                case (r_vsel)
                    VS_E1: begin
                        n_vsel = VS_E2; n_state = S_VLOAD;
                    end
                    VS_E2: begin
                        n_vsel = VS_U1; n_state = S_VLOAD;
                    end
                    VS_U1: begin
                        n_vsel = VS_U2; n_state = S_VLOAD;
                    end
                    VS_U2:   n_state = S_DET_MUL0;
                    default: n_state = S_OUT;
                endcase
            end
            S_DET_MUL0: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_DET0;
                n_state    = S_DET_ACC0;
            end
            S_DET_ACC0: begin
                o_cmd.op = OP_ACC_LOAD;
                n_state  = S_DET_MUL1;
            end
            S_DET_MUL1: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_DET1;
                n_state    = S_DET_ACC1;
            end
            S_DET_ACC1: begin
                o_cmd.op = OP_ACC_SUB;
                n_state  = S_DET_CHK;
            end
            S_DET_CHK: begin
                o_cmd.op = OP_DET_LATCH;
                n_idx    = '0;
                n_state  = i_stat.degen ? S_OUT : S_TV_MUL0;
            end
            S_TV_MUL0: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_TV0;
                n_state    = S_TV_ACC0;
            end
            S_TV_ACC0: begin
                o_cmd.op = OP_ACC_LOAD;
                n_state  = S_TV_MUL1;
            end
            S_TV_MUL1: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_TV1;
                n_state    = S_TV_ACC1;
            end
            S_TV_ACC1: begin
                o_cmd.op = OP_TV_STORE;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_vsel  = VS_TV;
                    n_state = S_VLOAD;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_TV_MUL0;
                end
            end
            S_OUT: begin
                // Wait for the output register to drain
                if (!i_stat.out_full) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_vsel   = VS_E1;
                    n_idx    = '0;
                    if (r_corner == 2'd2) begin
                        n_corner = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_corner = r_corner + 2'd1;
                        n_state  = S_VLOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/triangle_tangent_generator.sv =====
`timescale 1ns / 1ps
// Operation: the first two vertices of a triangle are held in corner registers.
// The third vertex starts four normalizations per corner (five when the UV
// determinant is usable) on one shared 32x32 multiplier and bit-serial
// square-root and divide units.
// Throughput: one triangle at a time; inputs are held off during the work.
// Reset: synchronous active-low; clears the corner count and the output valid flag.
// ----------------------------------------------------------------------------
// Triangle tangent generator
// Buffers two vertices, then on the third emits one unit tangent per corner.
// ----------------------------------------------------------------------------
module triangle_tangent_generator import tt_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    tt_in_if.sink   i_in,
    tt_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;
    t_vtx  w_vtx;
    t_res  w_res;
    logic  w_res_valid;
    logic  w_in_ready;

    // Gather the vertex word
    assign w_vtx.px = i_in.pos_x;
    assign w_vtx.py = i_in.pos_y;
    assign w_vtx.pz = i_in.pos_z;
    assign w_vtx.tu = i_in.tex_u;
    assign w_vtx.tv = i_in.tex_v;
    // Hold off the input while reset is asserted
    assign i_in.ready = w_in_ready && i_rst_n;

    tt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_vtx       (w_vtx),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_out.ready)
    );

    // Drive the tangent word
    assign o_out.valid            = w_res_valid;
    assign o_out.tangent_x        = w_res.tx;
    assign o_out.tangent_y        = w_res.ty;
    assign o_out.tangent_z        = w_res.tz;
    assign o_out.corner_index     = w_res.corner;
    assign o_out.degenerate       = w_res.degen;
    assign o_out.last_of_triangle = w_res.last;

    // The last word of a triangle is always the third corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_of_triangle == (o_out.corner_index == 2'd2)))
        else $error("last flag does not match corner index");

    // A degenerate corner carries the default tangent
    a_degen_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |->
            (o_out.tangent_x == TAN_HI[15:0] && o_out.tangent_y == 16'sd0 &&
             o_out.tangent_z == 16'sd0))
        else $error("degenerate word without default tangent");

    // Inputs are held off once a triangle is being worked
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_CAPTURE) |=> !i_in.ready)
        else $error("input taken while a triangle is in progress");

    // The x tangent component stays within the clamp range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.tangent_x) <= TAN_HI &&
                         $signed(o_out.tangent_x) >= TAN_LO))
        else $error("tangent component out of range");

endmodule
